FILE: sv/sbpg_pkg.sv
// shared types and constants for the spectrum bin power to gray block
// no dependencies
`timescale 1ns / 1ps

package sbpg_pkg;

  localparam int SBPG_LINES       = 512;
  localparam int SBPG_MAX_AVERAGE = 32;
  localparam int SBPG_FIFO_DEPTH  = 4;

  localparam int AVG_W  = 7;
  localparam int LINE_W = 9;
  localparam int DB_W   = 13;

  localparam logic signed [DB_W-1:0] DB_MIN = -13'sd2048;
  localparam logic signed [DB_W-1:0] DB_MAX = 13'sd4095;
  localparam logic [17:0] LOG10_2_Q16 = 18'd197283;

  localparam logic [1:0] CFG_AVERAGE   = 2'd0;
  localparam logic [1:0] CFG_GRAY_LOW  = 2'd1;
  localparam logic [1:0] CFG_GRAY_HIGH = 2'd2;

  typedef struct packed {
    logic [63:0]       sum;
    logic [AVG_W-1:0]  avg;
    logic [LINE_W-1:0] line;
  } group_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_NORM,
    BK_SQR,
    BK_DB,
    BK_PREP,
    BK_DIV,
    BK_DONE
  } back_state_t;

endpackage

FILE: sv/sbpg_front.sv
// front end: squares bins, accumulates group power, issues finished groups
// depends on sbpg_pkg
`timescale 1ns / 1ps

module sbpg_front import sbpg_pkg::*; #(
  parameter int LINES       = SBPG_LINES,
  parameter int MAX_AVERAGE = SBPG_MAX_AVERAGE
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] bin_real,
  input  logic signed [31:0] bin_imag,
  input  logic               frame_start,
  input  logic [5:0]         average_count,
  output logic               push,
  output group_t             push_data,
  input  logic               full
);

  localparam int GW = $clog2(LINES);
  localparam logic [GW:0]      HALF = (GW+1)'(LINES / 2);
  localparam logic [GW:0]      LIN  = (GW+1)'(LINES);
  localparam logic [GW-1:0]    LAST = GW'(LINES - 1);
  localparam logic [AVG_W-1:0] MAXA = AVG_W'(MAX_AVERAGE);

  logic          s1_valid;
  logic          s1_frame;
  logic [63:0]   sq_re;
  logic [63:0]   sq_im;
  logic [63:0]   power_sum;
  logic [5:0]    fill;
  logic [GW-1:0] gnum;

  logic [AVG_W-1:0] eff;
  logic [63:0]      base_sum;
  logic [5:0]       base_fill;
  logic [GW-1:0]    base_gn;
  logic [63:0]      mag;
  logic [65:0]      total;
  logic [63:0]      sat;
  logic [5:0]       fill_next;
  logic             done;
  logic             advance;
  logic [GW:0]      ln_wide;
  logic [GW:0]      ln;
  logic [GW+9:0]    ln_ext;

  always_comb begin
    if (average_count == 6'd0) begin
      eff = AVG_W'(1);
    end else if (AVG_W'(average_count) > MAXA) begin
      eff = MAXA;
    end else begin
      eff = AVG_W'(average_count);
    end
    base_sum  = s1_frame ? 64'd0 : power_sum;
    base_fill = s1_frame ? 6'd0 : fill;
    base_gn   = s1_frame ? '0 : gnum;
    mag       = sq_re + sq_im;
    total     = {2'b00, base_sum} + {1'b0, mag, 1'b0};
    sat       = (total[65:64] != 2'b00) ? {64{1'b1}} : total[63:0];
    fill_next = base_fill + 6'd1;
    done      = AVG_W'(fill_next) >= eff;
    advance   = s1_valid && (!done || !full);
    push      = s1_valid && done && !full;
    in_stall  = s1_valid && !advance;
    ln_wide   = {1'b0, base_gn} + HALF;
    ln        = (ln_wide >= LIN) ? ln_wide - LIN : ln_wide;
    ln_ext    = {9'd0, ln};
    push_data.sum  = sat;
    push_data.avg  = eff;
    push_data.line = ln_ext[8:0];
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      sq_re    <= 64'(bin_real) * 64'(bin_real);
      sq_im    <= 64'(bin_imag) * 64'(bin_imag);
      s1_frame <= frame_start;
    end
    if (rst) begin
      s1_valid  <= 1'b0;
      power_sum <= 64'd0;
      fill      <= 6'd0;
      gnum      <= '0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        if (done) begin
          power_sum <= 64'd0;
          fill      <= 6'd0;
          gnum      <= (base_gn == LAST) ? '0 : base_gn + GW'(1);
        end else begin
          power_sum <= sat;
          fill      <= fill_next;
          gnum      <= base_gn;
        end
      end
    end
  end

endmodule

FILE: sv/sbpg_fifo.sv
// short group queue between front and back ends
// depends on sbpg_pkg
`timescale 1ns / 1ps

module sbpg_fifo import sbpg_pkg::*; #(
  parameter int DEPTH = SBPG_FIFO_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  group_t push_data,
  output logic   full,
  input  logic   pop,
  output group_t rd_data,
  output logic   empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  group_t        mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = count == CW'(DEPTH);
  assign empty   = count == '0;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: sv/sbpg_back.sv
// back end: log2 by squaring, dB scaling, gray mapping by restoring division
// depends on sbpg_pkg
`timescale 1ns / 1ps

module sbpg_back import sbpg_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  output logic                     pop,
  input  logic                     empty,
  input  group_t                   rd_data,
  input  logic signed [8:0]        gray_low,
  input  logic signed [8:0]        gray_high,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [LINE_W-1:0]        line_index,
  output logic signed [DB_W-1:0]   power_db,
  output logic [7:0]               pixel
);

  back_state_t state;
  back_state_t state_next;

  logic [LINE_W-1:0]      line_q;
  logic [AVG_W-1:0]       avg_q;
  logic [63:0]            x;
  logic [5:0]             e;
  logic [5:0]             sh;
  logic [31:0]            m;
  logic [15:0]            frac;
  logic [3:0]             cnt;
  logic                   phase;
  logic [21:0]            ls;
  logic [21:0]            la;
  logic signed [DB_W-1:0] db;
  logic [7:0]             pix;
  logic                   use_div;
  logic [22:0]            rem;
  logic [22:0]            dv;
  logic [8:0]             quo;

  logic              load_out;
  logic              slot_free;
  logic              top_zero;
  logic [63:0]       xs;
  logic [5:0]        es;
  logic [63:0]       sq;
  logic [32:0]       sqh;
  logic [15:0]       frac_next;
  logic signed [22:0] dlog;
  logic signed [41:0] prod;
  logic signed [41:0] qdb;
  logic signed [9:0]  gdiff;
  logic signed [23:0] den;
  logic signed [23:0] dd;
  logic signed [23:0] n;
  logic signed [23:0] two_n_den;
  logic signed [23:0] lim;
  logic signed [23:0] t;
  logic               empty_range;
  logic               direct;
  logic [7:0]         direct_pix;
  logic [8:0]         r;
  logic [7:0]         fin_pix;

  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    top_zero  = (x & ~({64{1'b1}} >> sh)) == 64'd0;
    xs        = top_zero ? x << sh : x;
    es        = top_zero ? e - sh : e;
    sq        = 64'(m) * 64'(m);
    sqh       = sq[63:31];
    frac_next = {frac[14:0], sqh[32]};
    dlog      = $signed({1'b0, ls}) - $signed({1'b0, la});
    prod      = 42'(dlog) * $signed({24'd0, LOG10_2_Q16}) + (42'sd1 <<< 27);
    qdb       = prod >>> 28;
    gdiff     = 10'(gray_high) - 10'(gray_low);
    den       = 24'(gdiff) <<< 4;
    dd        = 24'(db) - (24'(gray_low) <<< 4);
    n         = dd * 24'sd255;
    two_n_den = (n <<< 1) + den;
    lim       = den * 24'sd510;
    t         = n + den;
    empty_range = gray_high <= gray_low;
    direct    = 1'b1;
    direct_pix = 8'd255;
    if (empty_range) begin
      direct_pix = (dd >= 24'sd0) ? 8'd0 : 8'd255;
    end else if (two_n_den < 24'sd0) begin
      direct_pix = 8'd255;
    end else if (two_n_den > lim) begin
      direct_pix = 8'd0;
    end else begin
      direct = 1'b0;
    end
    r       = (rem == 23'd0 && quo[0]) ? quo - 9'd1 : quo;
    fin_pix = 8'd255 - ((r > 9'd255) ? 8'd255 : r[7:0]);
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!empty) begin
          state_next = (rd_data.sum == 64'd0) ? BK_PREP : BK_NORM;
        end
      end
      BK_NORM: begin
        if (sh == 6'd1) begin
          state_next = BK_SQR;
        end
      end
      BK_SQR: begin
        if (cnt == 4'd15) begin
          state_next = phase ? BK_DB : BK_NORM;
        end
      end
      BK_DB:   state_next = BK_PREP;
      BK_PREP: state_next = direct ? BK_DONE : BK_DIV;
      BK_DIV: begin
        if (cnt == 4'd0) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (slot_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop      = (state == BK_IDLE) && !empty;
    load_out = (state == BK_DONE) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        line_q <= rd_data.line;
        avg_q  <= rd_data.avg;
        x      <= rd_data.sum;
        e      <= 6'd63;
        sh     <= 6'd32;
        phase  <= 1'b0;
        db     <= DB_MIN;
      end
      BK_NORM: begin
        x    <= xs;
        e    <= es;
        sh   <= sh >> 1;
        m    <= xs[63:32];
        frac <= 16'd0;
        cnt  <= 4'd0;
      end
      BK_SQR: begin
        m    <= sqh[32] ? sqh[32:1] : sqh[31:0];
        frac <= frac_next;
        cnt  <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          if (!phase) begin
            ls    <= {e, frac_next};
            phase <= 1'b1;
            x     <= 64'(avg_q);
            e     <= 6'd63;
            sh    <= 6'd32;
          end else begin
            la <= {e, frac_next};
          end
        end
      end
      BK_DB: begin
        if (qdb < 42'(DB_MIN)) begin
          db <= DB_MIN;
        end else if (qdb > 42'(DB_MAX)) begin
          db <= DB_MAX;
        end else begin
          db <= qdb[DB_W-1:0];
        end
      end
      BK_PREP: begin
        use_div <= !direct;
        pix     <= direct_pix;
        rem     <= t[22:0];
        dv      <= 23'(den) << 8;
        quo     <= 9'd0;
        cnt     <= 4'd8;
      end
      BK_DIV: begin
        if (rem >= dv) begin
          rem <= rem - dv;
          quo <= {quo[7:0], 1'b1};
        end else begin
          quo <= {quo[7:0], 1'b0};
        end
        dv  <= dv >> 1;
        cnt <= cnt - 4'd1;
      end
      BK_DONE: begin
        if (load_out) begin
          line_index <= line_q;
          power_db   <= db;
          pixel      <= use_div ? fin_pix : pix;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: sv/spectrum_bin_power_to_gray.sv
// top level: configuration registers, front end, group queue, back end
// depends on sbpg_pkg, sbpg_front, sbpg_fifo, sbpg_back
`timescale 1ns / 1ps
//
// Input channel (in_valid/in_stall) takes one FFT bin per word, bin_real,
// bin_imag and frame_start; frame_start clears the group sum, fill and line
// counter before its bin is added. The front end takes one bin per cycle
// while in_stall is low: squares are registered, then summed into a
// saturating 64-bit accumulator. Every average_count bins (0 counts as 1,
// capped at MAX_AVERAGE) a finished group enters a four-entry queue.
// The back end turns one group into a result word (line_index, power_db,
// pixel) on the output channel (out_valid/out_stall): two log2 passes
// of 6 normalize and 16 squaring steps on one 32x32 multiplier, a dB
// scaling step, a setup step, 9 division steps and a load step at each
// end. The division is skipped when the pixel clamps; a zero-power
// group skips the log2 passes and the dB scaling. Bins stream at
// one per cycle until the queue fills; then the input is held to one group
// per back-end pass.
// A stalled result word holds in the output register while the back end
// works on the next group. Configuration writes (cfg_valid/cfg_ready,
// always ready) take effect at once and should be made while idle.
// Reset clears counters, queue and output valid, and loads average_count
// 1, gray_low 40 and gray_high 140.

module spectrum_bin_power_to_gray import sbpg_pkg::*; #(
  parameter int LINES       = SBPG_LINES,
  parameter int MAX_AVERAGE = SBPG_MAX_AVERAGE
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [31:0]     bin_real,
  input  logic signed [31:0]     bin_imag,
  input  logic                   frame_start,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [LINE_W-1:0]      line_index,
  output logic signed [DB_W-1:0] power_db,
  output logic [7:0]             pixel,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [8:0]             cfg_data
);

  logic [5:0]        average_count;
  logic signed [8:0] gray_low;
  logic signed [8:0] gray_high;

  logic   push;
  logic   pop;
  logic   full;
  logic   empty;
  group_t push_data;
  group_t rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      average_count <= 6'd1;
      gray_low      <= 9'sd40;
      gray_high     <= 9'sd140;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_AVERAGE:   average_count <= cfg_data[5:0];
        CFG_GRAY_LOW:  gray_low      <= cfg_data;
        CFG_GRAY_HIGH: gray_high     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sbpg_front #(
    .LINES       (LINES),
    .MAX_AVERAGE (MAX_AVERAGE)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .bin_real      (bin_real),
    .bin_imag      (bin_imag),
    .frame_start   (frame_start),
    .average_count (average_count),
    .push          (push),
    .push_data     (push_data),
    .full          (full)
  );

  sbpg_fifo #(
    .DEPTH (SBPG_FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .rd_data   (rd_data),
    .empty     (empty)
  );

  sbpg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop        (pop),
    .empty      (empty),
    .rd_data    (rd_data),
    .gray_low   (gray_low),
    .gray_high  (gray_high),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .line_index (line_index),
    .power_db   (power_db),
    .pixel      (pixel)
  );

endmodule

FILE: sv/sbpg_checker.sv
// port-level checks on the result channel of the top level
// depends on sbpg_pkg; bound to spectrum_bin_power_to_gray
`timescale 1ns / 1ps

module sbpg_props import sbpg_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [LINE_W-1:0]      line_index,
  input logic signed [DB_W-1:0] power_db,
  input logic [7:0]             pixel
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel) && $stable(power_db)
      && $stable(line_index))
    else $error("stalled result word changed");

  a_db_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(power_db[12] && !power_db[11]))
    else $error("power_db below minimum");

endmodule

bind spectrum_bin_power_to_gray sbpg_props u_chk (.*);
